// ----- rtl/lie_pkg.sv -----
package lie_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned NODE_SLOTS = 4;
  localparam int unsigned NODE_IDX_W = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned Y_W = 32;
  localparam int unsigned ST_W = 2;
  localparam int unsigned NUM_W = 64;
  localparam int unsigned DEN_W = 56;
  localparam int unsigned QOT_W = 64;

  typedef enum logic [ST_W-1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DUP = 2'd2
  } status_t;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ----- rtl/lie_stream_if.sv -----
interface lie_stream_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/lagrange_interpolation_eval.sv -----
// Lagrange interpolation evaluator over NUM_POINTS configured nodes (Q7.8). Each request
// carries one sample x; each response gives the Q23.8 value, saturated, and a status
// (ok, saturated, duplicate node x with zero value). One request is taken every cycle
// while the output is not stalled; the latency is set mostly by the 64-stage bit-per-stage
// divider that rounds each term. A stalled output freezes the whole pipeline. The user
// must write node registers only while idle; the block itself does not enforce it.
module lagrange_interpolation_eval #(
  parameter int unsigned NUM_POINTS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lie_stream_if.sink                           in_s,
  lie_stream_if.source                         out_s,
  input  logic                                 cfg_we,
  input  logic [lie_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lie_pkg::COORD_W-1:0]          cfg_data
);
  localparam int unsigned NS = lie_pkg::NODE_SLOTS;
  localparam int unsigned NW = lie_pkg::NUM_W;
  localparam int unsigned DW = lie_pkg::DEN_W;
  localparam int unsigned LAT = NW + 10;

  logic signed [15:0] nx_r [NS];
  logic signed [15:0] ny_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        nx_r[k] <= 16'(k * 256);
        ny_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (!cfg_index[2]) nx_r[cfg_index[1:0]] <= cfg_data;
      else ny_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  // Node-only quantities are constant while streaming; compute them combinationally
  // from the registers and register them into stage 1 alongside each request.
  logic dup;
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < NUM_POINTS; i++)
      for (int j = i + 1; j < NUM_POINTS; j++)
        if (nx_r[i] == nx_r[j]) dup = 1'b1;
  end

  logic [LAT-1:0] v_r;
  logic en;
  assign en = !v_r[LAT-1] || out_s.ready;
  assign in_s.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_s.valid};
  end

  // Stage 1: differences. The sample differences travel with the request so that each
  // multiply stage sees the ones of its own request.
  logic signed [16:0] dx_r [4][NS];
  logic signed [16:0] dn_r [NS][NS];
  logic signed [15:0] y1_r [NS];
  logic [LAT-1:0] dup_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        dx_r[0][j] <= 17'($signed(in_s.data[15:0])) - 17'(nx_r[j]);
        for (int k = 1; k < 4; k++) dx_r[k][j] <= dx_r[k-1][j];
      end
      for (int i = 0; i < NS; i++) begin
        y1_r[i] <= ny_r[i];
        for (int j = 0; j < NS; j++) begin
          dn_r[i][j] <= 17'(nx_r[i]) - 17'(nx_r[j]);
        end
      end
      dup_r <= {dup_r[LAT-2:0], dup};
    end
  end

  // Stages 2-5: stage 2 loads each term, then one multiply per stage per term; unused factors are one.
  logic signed [NW-1:0] num_r [4][NS];
  logic signed [DW-1:0] den_r [4][NS];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        num_r[0][i] <= NW'(y1_r[i]);
        den_r[0][i] <= DW'(1);
      end
      for (int s = 0; s < 3; s++)
        for (int i = 0; i < NS; i++) begin
          int j;
          j = (s >= i) ? s + 1 : s;
          if (i < NUM_POINTS && j < NUM_POINTS) begin
            num_r[s+1][i] <= NW'(num_r[s][i] * NW'(dx_r[s+1][j]));
            den_r[s+1][i] <= DW'(den_r[s][i] * DW'(dn_r[i][j]));
          end else begin
            num_r[s+1][i] <= num_r[s][i];
            den_r[s+1][i] <= den_r[s][i];
          end
        end
    end
  end

  // Stage 6: magnitudes for the dividers.
  logic [NW-1:0] nm_r [NS];
  logic [DW-1:0] dm_r [NS];
  logic          ng_r [NS];
  always_ff @(posedge clk) begin
    if (en)
      for (int i = 0; i < NS; i++) begin
        nm_r[i] <= num_r[3][i][NW-1] ? -num_r[3][i] : num_r[3][i];
        dm_r[i] <= (den_r[3][i][DW-1] ? -den_r[3][i] : den_r[3][i]);
        ng_r[i] <= num_r[3][i][NW-1] ^ den_r[3][i][DW-1];
      end
  end

  logic signed [NW:0] q [NS];
  for (genvar i = 0; i < NS; i++) begin : g_div
    lie_divider u_div (
      .clk(clk), .en(en), .num_mag(nm_r[i]),
      .den_mag((i < NUM_POINTS) ? dm_r[i] : DW'(1)),
      .neg_in(ng_r[i]), .quot(q[i])
    );
  end

  // Sum stages, then saturate.
  logic signed [NW+2:0] s01_r, s23_r, sum_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s01_r <= (NW+3)'(q[0]) + (NUM_POINTS > 1 ? (NW+3)'(q[1]) : '0);
      s23_r <= (NUM_POINTS > 2 ? (NW+3)'(q[2]) : '0)
             + (NUM_POINTS > 3 ? (NW+3)'(q[3]) : '0);
      sum_r <= s01_r + s23_r;
    end
  end

  logic [31:0] y_r;
  logic [1:0]  st_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (dup_r[LAT-2]) begin
        y_r <= '0;
        st_r <= lie_pkg::ST_DUP;
      end else if (sum_r > (NW+3)'(32'sh7FFFFFFF)) begin
        y_r <= 32'h7FFFFFFF;
        st_r <= lie_pkg::ST_SAT;
      end else if (sum_r < -(NW+3)'(33'sh080000000)) begin
        y_r <= 32'h80000000;
        st_r <= lie_pkg::ST_SAT;
      end else begin
        y_r <= sum_r[31:0];
        st_r <= lie_pkg::ST_OK;
      end
    end
  end

  assign out_s.valid = v_r[LAT-1];
  assign out_s.data = {st_r, y_r};
endmodule

// ----- rtl/lie_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, rounded to nearest with ties
// away from zero. The stage enable advances all stages together.
module lie_divider (
  input  logic                              clk,
  input  logic                              en,
  input  logic [lie_pkg::NUM_W-1:0]         num_mag,
  input  logic [lie_pkg::DEN_W-1:0]         den_mag,
  input  logic                              neg_in,
  output logic signed [lie_pkg::QOT_W:0]    quot
);
  localparam int unsigned NW = lie_pkg::NUM_W;
  localparam int unsigned DW = lie_pkg::DEN_W;

  logic [NW-1:0] n_r [NW+1];
  logic [DW:0]   r_r [NW+1];
  logic [DW-1:0] d_r [NW+1];
  logic          s_r [NW+1];

  always_comb begin
    n_r[0] = num_mag;
    r_r[0] = '0;
    d_r[0] = den_mag;
    s_r[0] = neg_in;
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW+1:0] trial;
    logic [NW-1:0] n_nxt;
    logic [DW:0]   r_nxt;
    always_comb begin
      trial = {r_r[k], n_r[k][NW-1]} - {2'b00, d_r[k]};
      if (!trial[DW+1]) begin
        r_nxt = trial[DW:0];
        n_nxt = {n_r[k][NW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[k][DW-1:0], n_r[k][NW-1]};
        n_nxt = {n_r[k][NW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1] <= n_nxt;
        r_r[k+1] <= r_nxt;
        d_r[k+1] <= d_r[k];
        s_r[k+1] <= s_r[k];
      end
    end
  end

  logic [DW+1:0] twice_r;
  logic [NW:0]   q_rnd;
  always_comb begin
    twice_r = {r_r[NW], 1'b0};
    q_rnd = {1'b0, n_r[NW]} + {{NW{1'b0}}, (twice_r >= {2'b00, d_r[NW]})};
  end

  logic signed [NW:0] q_r;
  always_ff @(posedge clk) begin
    if (en) q_r <= s_r[NW] ? -$signed(q_rnd) : $signed(q_rnd);
  end
  assign quot = q_r;
endmodule
